// ----- hdl/srwc_pkg.sv -----
package srwc_pkg;

	localparam int SEQ_W      = 64;
	localparam int IN_TDATA_W  = 64;
	localparam int RES_W       = 2 + 2 * SEQ_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// bit positions of the result fields inside m_tdata
	localparam int VERDICT_LSB  = 0;
	localparam int EXPECTED_LSB = 2;
	localparam int HIGHEST_LSB  = 2 + SEQ_W;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_GAP    = 2'd1,
		VERDICT_REPLAY = 2'd2
	} verdict_t;

	// packed lowest field last, so it lands in the low bits
	typedef struct packed {
		logic [SEQ_W-1:0] highest;
		logic [SEQ_W-1:0] expected;
		verdict_t         verdict;
	} result_t;

endpackage

// ----- hdl/srwc_core.sv -----
module srwc_core #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [srwc_pkg::SEQ_W-1:0] seq,
	output srwc_pkg::result_t          res
);

	localparam int IW = $clog2(WINDOW_BITS);
	localparam logic [srwc_pkg::SEQ_W-1:0] WIN  = srwc_pkg::SEQ_W'(WINDOW_BITS);
	localparam logic [srwc_pkg::SEQ_W-1:0] HALF = srwc_pkg::SEQ_W'(WINDOW_BITS / 2);

	logic [srwc_pkg::SEQ_W-1:0] highest_q, next_q, start_q;
	logic [WINDOW_BITS-1:0]     seen_q;

	logic [srwc_pkg::SEQ_W-1:0] off_old, off_new, new_start, slide_dist, start_nx;
	logic [srwc_pkg::SEQ_W-1:0] highest_nx, next_nx;
	logic [WINDOW_BITS-1:0]     shifted, seen_nx;
	logic                       is_new, in_old, in_new, slide, bit_old, set_en;
	logic [IW-1:0]              set_idx;
	srwc_pkg::verdict_t         verdict;

	always_comb begin
		off_old    = seq - start_q;
		in_old     = (seq >= start_q) && (off_old < WIN);
		is_new     = seq > highest_q;
		slide      = off_old >= WIN;
		new_start  = seq - HALF;
		slide_dist = new_start - start_q;

		// slide the bitmap down, clear freed bits at the top
		if (slide_dist >= WIN) begin
			shifted = '0;
		end else begin
			shifted = seen_q >> slide_dist[IW-1:0];
		end

		start_nx = (is_new && slide) ? new_start : start_q;
		off_new  = seq - start_nx;
		in_new   = (seq >= start_nx) && (off_new < WIN);
		bit_old  = in_old ? seen_q[off_old[IW-1:0]] : 1'b1;

		set_idx = is_new ? off_new[IW-1:0] : off_old[IW-1:0];
		set_en  = is_new ? in_new : !bit_old;

		seen_nx = (is_new && slide) ? shifted : seen_q;
		if (set_en) begin
			seen_nx[set_idx] = 1'b1;
		end

		if (is_new) begin
			verdict = (seq > next_q) ? srwc_pkg::VERDICT_GAP : srwc_pkg::VERDICT_ACCEPT;
		end else begin
			verdict = set_en ? srwc_pkg::VERDICT_ACCEPT : srwc_pkg::VERDICT_REPLAY;
		end

		highest_nx = is_new ? seq : highest_q;
		next_nx    = is_new ? (seq + srwc_pkg::SEQ_W'(1)) : next_q;

		res.verdict  = verdict;
		res.expected = next_nx;
		res.highest  = highest_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
			next_q    <= srwc_pkg::SEQ_W'(1);
			start_q   <= '0;
			seen_q    <= '0;
		end else if (step) begin
			highest_q <= highest_nx;
			next_q    <= next_nx;
			start_q   <= start_nx;
			seen_q    <= seen_nx;
		end
	end

endmodule

// ----- hdl/srwc_out_reg.sv -----
module srwc_out_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  srwc_pkg::result_t                res,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [srwc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic              valid_q;
	srwc_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {(srwc_pkg::OUT_TDATA_W - srwc_pkg::RES_W)'(0), res_q};

endmodule

// ----- hdl/sequence_replay_window_check.sv -----
// Anti-replay window check for 64-bit sequence numbers. Each request on the
// slave side carries one sequence number and yields exactly one result on the
// master side: a verdict (accepted, accepted with a gap, or replay), the next
// expected sequence and the highest accepted sequence after that request.
// The block keeps a WINDOW_BITS-wide seen bitmap in flip-flops; a new highest
// sequence beyond the window slides the window so its start becomes
// seq - WINDOW_BITS/2, shifting the bitmap by that distance in the same cycle.
// Throughput is one request per clock while the master side does not stall; a
// request taken into the input register passes compare, barrel shift and bit
// update and lands in the result register, where it shows on m_tvalid. The
// state update of one request is visible to the very next one, so no hazards
// exist. After reset the block is ready at once; no clearing pass is needed.
module sequence_replay_window_check #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [63:0] seq_number
	input  logic [srwc_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] verdict, [65:2] expected_seq, [129:66] highest_seq, [135:130] zero
	output logic [srwc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic                       valid_s1;
	logic [srwc_pkg::SEQ_W-1:0] seq_s1;
	logic                       can_out;
	logic                       fire;
	srwc_pkg::result_t          res;

	// result register free, or being emptied this cycle
	assign can_out  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && can_out;
	// input stage takes a new request when empty or moving on
	assign s_tready = !valid_s1 || can_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			seq_s1 <= s_tdata[srwc_pkg::SEQ_W-1:0];
		end
	end

	// window state and the single-pass classify / slide / mark logic
	srwc_core #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire),
		.seq   (seq_s1),
		.res   (res)
	);

	// result register toward the master side
	srwc_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.res     (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ----- hdl/srwc_checker.sv -----
module srwc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [srwc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [srwc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0]                 verdict;
	logic [srwc_pkg::SEQ_W-1:0] expected, highest;

	assign verdict  = m_tdata[srwc_pkg::VERDICT_LSB +: 2];
	assign expected = m_tdata[srwc_pkg::EXPECTED_LSB +: srwc_pkg::SEQ_W];
	assign highest  = m_tdata[srwc_pkg::HIGHEST_LSB +: srwc_pkg::SEQ_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no unused verdict code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> verdict <= srwc_pkg::VERDICT_REPLAY)
		else $error("bad verdict code");

	// expected always follows highest by one
	a_track: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> expected == highest + srwc_pkg::SEQ_W'(1))
		else $error("expected and highest out of step");

	// empty output side never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// replay leaves highest unchanged from the previous result
	a_replay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && verdict == srwc_pkg::VERDICT_REPLAY
		|-> highest == $past(highest))
		else $error("replay moved highest");

endmodule

bind sequence_replay_window_check srwc_checker u_srwc_checker (.*);
